// ===== hdl/rmsm_pkg.sv =====
`default_nettype none

package rmsm_pkg;

  // defaults of the top level parameters
  localparam int PHASE_COUNT_DEF = 3;
  localparam int ADC_BITS_DEF    = 10;
  localparam int MAX_WINDOW_DEF  = 1024;

  // fixed field widths
  localparam int PHASE_W    = 2;
  localparam int OUT_W      = 14;
  localparam int CNT_CFG_W  = 11;
  localparam int GAIN_W     = 24;
  localparam int FLOOR_W    = 14;
  localparam int GAIN_FRAC  = 20;
  localparam int OFS_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_FLOOR  = 3'd5;

  // configuration reset values
  localparam logic [CNT_CFG_W-1:0] WINDOW_RST      = 11'd400;
  localparam logic [CNT_CFG_W-1:0] CAL_SAMPLES_RST = 11'd1000;
  localparam logic [GAIN_W-1:0]    VOLT_GAIN_RST   = 24'd866740;
  localparam logic [GAIN_W-1:0]    CURR_GAIN_RST   = 24'd485326;
  localparam logic [FLOOR_W-1:0]   VOLT_FLOOR_RST  = 14'd50;
  localparam logic [FLOOR_W-1:0]   CURR_FLOOR_RST  = 14'd8;

  // command and result kind codes
  localparam logic MODE_CAL  = 1'b0;
  localparam logic MODE_MEAS = 1'b1;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_CAL,
    ST_CAL_DV,
    ST_CAL_DI,
    ST_SQ_V,
    ST_SQ_I,
    ST_DIV_V,
    ST_SQRT_V,
    ST_GAIN_V,
    ST_DIV_I,
    ST_SQRT_I,
    ST_GAIN_I,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/three_phase_rms_meter.sv =====
`default_nettype none

// Three-phase true RMS meter. Each input word carries a voltage and a current
// ADC code tagged with a phase. Command 0 words are averaged per phase into
// zero offsets (4 fractional bits); after calibration_samples of them a result
// word of kind 0 reports the new offsets. Command 1 words have the offsets
// removed and their squared deviations summed per phase; after window_samples
// of them a result word of kind 1 reports RMS voltage in 0.1 V and RMS current
// in 0.01 A, saturated at 16383 and forced to zero below the floors. Switching
// command clears every sum and counter; a phase at or above PHASE_COUNT is
// dropped without a result. All arithmetic runs on one shared radix-2 unit
// (multiply, divide, square root, one bit per cycle), so one word is handled
// at a time and in_ready is low meanwhile. With default parameters a
// measurement word needs two 22-step squarings; a word that closes a window
// also needs per channel a 56-step divide, a 28-step square root and a
// 24-step gain multiply. A word that closes the calibration also needs two
// 56-step divides. A finished result waits in the output register while the
// next word is already taken in. Config writes are always accepted.
module three_phase_rms_meter #(
  parameter int PHASE_COUNT = rmsm_pkg::PHASE_COUNT_DEF,
  parameter int ADC_BITS    = rmsm_pkg::ADC_BITS_DEF,
  parameter int MAX_WINDOW  = rmsm_pkg::MAX_WINDOW_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // config write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [rmsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [rmsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // sample channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_command,
  input  wire  [rmsm_pkg::PHASE_W-1:0]      in_phase,
  input  wire  [ADC_BITS-1:0]               in_voltage_code,
  input  wire  [ADC_BITS-1:0]               in_current_code,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_result_kind,
  output logic [rmsm_pkg::PHASE_W-1:0]      out_result_phase,
  output logic [rmsm_pkg::OUT_W-1:0]        out_voltage_rms,
  output logic [rmsm_pkg::OUT_W-1:0]        out_current_rms
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PH_W   = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam int CAL_W  = ADC_BITS + CNT_W;               // calibration sum
  localparam int OFS_W  = rmsm_pkg::OFS_W;
  localparam int SQ_W   = 2 * OFS_W;                      // one squared deviation
  localparam int SQS_W  = SQ_W + CNT_W;                   // square sum
  localparam int DATA_W = 2 * ((SQS_W + 1) / 2);          // even, for bit-pair sqrt
  localparam int STEP_W = $clog2(DATA_W + 1);
  localparam int VAL_W  = DATA_W - rmsm_pkg::GAIN_FRAC;
  localparam int OUT_W  = rmsm_pkg::OUT_W;
  localparam logic [OFS_W-1:0] OFS_RST = OFS_W'(64'd1 << (ADC_BITS + 3));

  // configuration registers
  logic [rmsm_pkg::CNT_CFG_W-1:0] win_r, win_nxt;
  logic [rmsm_pkg::CNT_CFG_W-1:0] cal_n_r, cal_n_nxt;
  logic [rmsm_pkg::GAIN_W-1:0]    v_gain_r, v_gain_nxt;
  logic [rmsm_pkg::GAIN_W-1:0]    i_gain_r, i_gain_nxt;
  logic [rmsm_pkg::FLOOR_W-1:0]   v_floor_r, v_floor_nxt;
  logic [rmsm_pkg::FLOOR_W-1:0]   i_floor_r, i_floor_nxt;

  // per-phase state
  logic [OFS_W-1:0] v_ofs_r [PHASE_COUNT];
  logic [OFS_W-1:0] v_ofs_nxt [PHASE_COUNT];
  logic [OFS_W-1:0] i_ofs_r [PHASE_COUNT];
  logic [OFS_W-1:0] i_ofs_nxt [PHASE_COUNT];
  logic [SQS_W-1:0] v_sq_r [PHASE_COUNT];
  logic [SQS_W-1:0] v_sq_nxt [PHASE_COUNT];
  logic [SQS_W-1:0] i_sq_r [PHASE_COUNT];
  logic [SQS_W-1:0] i_sq_nxt [PHASE_COUNT];
  logic [CAL_W-1:0] v_cal_r [PHASE_COUNT];
  logic [CAL_W-1:0] v_cal_nxt [PHASE_COUNT];
  logic [CAL_W-1:0] i_cal_r [PHASE_COUNT];
  logic [CAL_W-1:0] i_cal_nxt [PHASE_COUNT];
  logic [CNT_W-1:0] cnt_r [PHASE_COUNT];
  logic [CNT_W-1:0] cnt_nxt [PHASE_COUNT];
  logic             last_mode_r, last_mode_nxt;

  // sequencer
  rmsm_pkg::state_t state_r, state_nxt;
  logic             go_r, go_nxt;

  // latched word and intermediate values
  logic                         cmd_r, cmd_nxt;
  logic [rmsm_pkg::PHASE_W-1:0] ph_r, ph_nxt;
  logic [ADC_BITS-1:0]          vc_r, vc_nxt;
  logic [ADC_BITS-1:0]          ic_r, ic_nxt;
  logic [SQ_W-1:0]              sq_v_r, sq_v_nxt;
  logic [OFS_W-1:0]             ofs_tmp_r, ofs_tmp_nxt;
  logic [OUT_W-1:0]             res_v_r, res_v_nxt;
  logic [OUT_W-1:0]             res_i_r, res_i_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [rmsm_pkg::PHASE_W-1:0] out_phase_r, out_phase_nxt;
  logic [OUT_W-1:0]             out_v_r, out_v_nxt;
  logic [OUT_W-1:0]             out_i_r, out_i_nxt;

  // shared unit
  logic                alu_start;
  rmsm_pkg::alu_op_t   alu_op;
  logic [DATA_W-1:0]   alu_a, alu_b;
  logic [STEP_W-1:0]   alu_steps;
  logic                alu_busy, alu_done;
  logic [DATA_W-1:0]   alu_res;

  // helpers
  logic [PH_W-1:0]  p;
  logic             in_acc;
  logic             ph_ok;
  logic [CNT_W-1:0] n_win, n_cal, cnt_inc;
  logic [OFS_W-1:0] code_v, code_i, dev_v, dev_i;
  logic [VAL_W-1:0] val;
  logic [OUT_W-1:0] val_sat, val_out, floor_sel;

  assign p        = PH_W'(ph_r);
  assign in_ready = (state_r == rmsm_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ph_ok    = (32'(in_phase) < PHASE_COUNT);
  assign cfg_ready = 1'b1;

  // zero counts act as one, large counts clip at the window limit
  assign n_win = (win_r == '0) ? CNT_W'(1) :
                 (32'(win_r) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(win_r);
  assign n_cal = (cal_n_r == '0) ? CNT_W'(1) :
                 (32'(cal_n_r) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(cal_n_r);
  assign cnt_inc = cnt_r[p] + 1'b1;

  // deviation from the zero offset, both in Q.4
  assign code_v = OFS_W'({vc_r, 4'b0000});
  assign code_i = OFS_W'({ic_r, 4'b0000});
  assign dev_v  = (code_v >= v_ofs_r[p]) ? (code_v - v_ofs_r[p]) : (v_ofs_r[p] - code_v);
  assign dev_i  = (code_i >= i_ofs_r[p]) ? (code_i - i_ofs_r[p]) : (i_ofs_r[p] - code_i);

  // gain product back to output units, saturate, then floor
  assign floor_sel = (state_r == rmsm_pkg::ST_GAIN_I) ? i_floor_r : v_floor_r;
  assign val       = alu_res[DATA_W-1:rmsm_pkg::GAIN_FRAC];
  assign val_sat   = (val[VAL_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : val[OUT_W-1:0];
  assign val_out   = (val_sat < floor_sel) ? '0 : val_sat;

  rmsm_alu #(
    .DATA_W (DATA_W)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .steps  (alu_steps),
    .busy   (alu_busy),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    cal_n_nxt     = cal_n_r;
    v_gain_nxt    = v_gain_r;
    i_gain_nxt    = i_gain_r;
    v_floor_nxt   = v_floor_r;
    i_floor_nxt   = i_floor_r;
    v_ofs_nxt     = v_ofs_r;
    i_ofs_nxt     = i_ofs_r;
    v_sq_nxt      = v_sq_r;
    i_sq_nxt      = i_sq_r;
    v_cal_nxt     = v_cal_r;
    i_cal_nxt     = i_cal_r;
    cnt_nxt       = cnt_r;
    last_mode_nxt = last_mode_r;
    cmd_nxt       = cmd_r;
    ph_nxt        = ph_r;
    vc_nxt        = vc_r;
    ic_nxt        = ic_r;
    sq_v_nxt      = sq_v_r;
    ofs_tmp_nxt   = ofs_tmp_r;
    res_v_nxt     = res_v_r;
    res_i_nxt     = res_i_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_phase_nxt = out_phase_r;
    out_v_nxt     = out_v_r;
    out_i_nxt     = out_i_r;
    alu_start     = go_r;
    alu_op        = rmsm_pkg::ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    alu_steps     = STEP_W'(OFS_W);

    // config writes land at once
    if (cfg_valid) begin
      case (cfg_index)
        rmsm_pkg::CFG_WINDOW:      win_nxt     = cfg_data[rmsm_pkg::CNT_CFG_W-1:0];
        rmsm_pkg::CFG_CAL_SAMPLES: cal_n_nxt   = cfg_data[rmsm_pkg::CNT_CFG_W-1:0];
        rmsm_pkg::CFG_VOLT_GAIN:   v_gain_nxt  = cfg_data[rmsm_pkg::GAIN_W-1:0];
        rmsm_pkg::CFG_CURR_GAIN:   i_gain_nxt  = cfg_data[rmsm_pkg::GAIN_W-1:0];
        rmsm_pkg::CFG_VOLT_FLOOR:  v_floor_nxt = cfg_data[rmsm_pkg::FLOOR_W-1:0];
        rmsm_pkg::CFG_CURR_FLOOR:  i_floor_nxt = cfg_data[rmsm_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      rmsm_pkg::ST_IDLE: begin
        if (in_acc && ph_ok) begin
          cmd_nxt = in_command;
          ph_nxt  = in_phase;
          vc_nxt  = in_voltage_code;
          ic_nxt  = in_current_code;
          // mode change wipes all running sums and counters
          if (in_command != last_mode_r) begin
            last_mode_nxt = in_command;
            for (int k = 0; k < PHASE_COUNT; k++) begin
              v_sq_nxt[k]  = '0;
              i_sq_nxt[k]  = '0;
              v_cal_nxt[k] = '0;
              i_cal_nxt[k] = '0;
              cnt_nxt[k]   = '0;
            end
          end
          state_nxt = (in_command == rmsm_pkg::MODE_CAL) ? rmsm_pkg::ST_ACC_CAL
                                                         : rmsm_pkg::ST_SQ_V;
        end
      end

      rmsm_pkg::ST_ACC_CAL: begin
        v_cal_nxt[p] = v_cal_r[p] + CAL_W'(vc_r);
        i_cal_nxt[p] = i_cal_r[p] + CAL_W'(ic_r);
        cnt_nxt[p]   = cnt_inc;
        state_nxt    = (cnt_inc < n_cal) ? rmsm_pkg::ST_IDLE : rmsm_pkg::ST_CAL_DV;
      end

      rmsm_pkg::ST_CAL_DV: begin
        alu_op    = rmsm_pkg::ALU_DIV;
        alu_a     = DATA_W'({v_cal_r[p], 4'b0000});
        alu_b     = DATA_W'(n_cal);
        alu_steps = STEP_W'(DATA_W);
        if (alu_done) begin
          ofs_tmp_nxt = alu_res[OFS_W-1:0];
          state_nxt   = rmsm_pkg::ST_CAL_DI;
        end
      end

      rmsm_pkg::ST_CAL_DI: begin
        alu_op    = rmsm_pkg::ALU_DIV;
        alu_a     = DATA_W'({i_cal_r[p], 4'b0000});
        alu_b     = DATA_W'(n_cal);
        alu_steps = STEP_W'(DATA_W);
        if (alu_done) begin
          v_ofs_nxt[p] = ofs_tmp_r;
          i_ofs_nxt[p] = alu_res[OFS_W-1:0];
          v_cal_nxt[p] = '0;
          i_cal_nxt[p] = '0;
          cnt_nxt[p]   = '0;
          res_v_nxt    = ofs_tmp_r[OUT_W-1:0];
          res_i_nxt    = alu_res[OUT_W-1:0];
          state_nxt    = rmsm_pkg::ST_EMIT;
        end
      end

      rmsm_pkg::ST_SQ_V: begin
        alu_op    = rmsm_pkg::ALU_MUL;
        alu_a     = DATA_W'(dev_v);
        alu_b     = DATA_W'(dev_v);
        alu_steps = STEP_W'(OFS_W);
        if (alu_done) begin
          sq_v_nxt  = alu_res[SQ_W-1:0];
          state_nxt = rmsm_pkg::ST_SQ_I;
        end
      end

      rmsm_pkg::ST_SQ_I: begin
        alu_op    = rmsm_pkg::ALU_MUL;
        alu_a     = DATA_W'(dev_i);
        alu_b     = DATA_W'(dev_i);
        alu_steps = STEP_W'(OFS_W);
        if (alu_done) begin
          v_sq_nxt[p] = v_sq_r[p] + SQS_W'(sq_v_r);
          i_sq_nxt[p] = i_sq_r[p] + SQS_W'(alu_res[SQ_W-1:0]);
          cnt_nxt[p]  = cnt_inc;
          state_nxt   = (cnt_inc < n_win) ? rmsm_pkg::ST_IDLE : rmsm_pkg::ST_DIV_V;
        end
      end

      rmsm_pkg::ST_DIV_V: begin
        alu_op    = rmsm_pkg::ALU_DIV;
        alu_a     = DATA_W'(v_sq_r[p]);
        alu_b     = DATA_W'(n_win);
        alu_steps = STEP_W'(DATA_W);
        if (alu_done) begin
          state_nxt = rmsm_pkg::ST_SQRT_V;
        end
      end

      rmsm_pkg::ST_SQRT_V: begin
        alu_op    = rmsm_pkg::ALU_SQRT;
        alu_a     = alu_res;
        alu_steps = STEP_W'(DATA_W / 2);
        if (alu_done) begin
          state_nxt = rmsm_pkg::ST_GAIN_V;
        end
      end

      rmsm_pkg::ST_GAIN_V: begin
        alu_op    = rmsm_pkg::ALU_MUL;
        alu_a     = alu_res;
        alu_b     = DATA_W'(v_gain_r);
        alu_steps = STEP_W'(rmsm_pkg::GAIN_W);
        if (alu_done) begin
          res_v_nxt = val_out;
          state_nxt = rmsm_pkg::ST_DIV_I;
        end
      end

      rmsm_pkg::ST_DIV_I: begin
        alu_op    = rmsm_pkg::ALU_DIV;
        alu_a     = DATA_W'(i_sq_r[p]);
        alu_b     = DATA_W'(n_win);
        alu_steps = STEP_W'(DATA_W);
        if (alu_done) begin
          state_nxt = rmsm_pkg::ST_SQRT_I;
        end
      end

      rmsm_pkg::ST_SQRT_I: begin
        alu_op    = rmsm_pkg::ALU_SQRT;
        alu_a     = alu_res;
        alu_steps = STEP_W'(DATA_W / 2);
        if (alu_done) begin
          state_nxt = rmsm_pkg::ST_GAIN_I;
        end
      end

      rmsm_pkg::ST_GAIN_I: begin
        alu_op    = rmsm_pkg::ALU_MUL;
        alu_a     = alu_res;
        alu_b     = DATA_W'(i_gain_r);
        alu_steps = STEP_W'(rmsm_pkg::GAIN_W);
        if (alu_done) begin
          res_i_nxt   = val_out;
          v_sq_nxt[p] = '0;
          i_sq_nxt[p] = '0;
          cnt_nxt[p]  = '0;
          state_nxt   = rmsm_pkg::ST_EMIT;
        end
      end

      rmsm_pkg::ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = cmd_r;
          out_phase_nxt = ph_r;
          out_v_nxt     = res_v_r;
          out_i_nxt     = res_i_r;
          state_nxt     = rmsm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rmsm_pkg::ST_IDLE;
      end
    endcase

    // one start pulse on entry to each unit operation
    go_nxt = (state_nxt != state_r) &&
             (state_nxt inside {rmsm_pkg::ST_CAL_DV, rmsm_pkg::ST_CAL_DI,
                                rmsm_pkg::ST_SQ_V, rmsm_pkg::ST_SQ_I,
                                rmsm_pkg::ST_DIV_V, rmsm_pkg::ST_SQRT_V,
                                rmsm_pkg::ST_GAIN_V, rmsm_pkg::ST_DIV_I,
                                rmsm_pkg::ST_SQRT_I, rmsm_pkg::ST_GAIN_I});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsm_pkg::ST_IDLE;
      go_r        <= 1'b0;
      win_r       <= rmsm_pkg::WINDOW_RST;
      cal_n_r     <= rmsm_pkg::CAL_SAMPLES_RST;
      v_gain_r    <= rmsm_pkg::VOLT_GAIN_RST;
      i_gain_r    <= rmsm_pkg::CURR_GAIN_RST;
      v_floor_r   <= rmsm_pkg::VOLT_FLOOR_RST;
      i_floor_r   <= rmsm_pkg::CURR_FLOOR_RST;
      last_mode_r <= rmsm_pkg::MODE_MEAS;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PHASE_COUNT; k++) begin
        v_ofs_r[k] <= OFS_RST;
        i_ofs_r[k] <= OFS_RST;
        v_sq_r[k]  <= '0;
        i_sq_r[k]  <= '0;
        v_cal_r[k] <= '0;
        i_cal_r[k] <= '0;
        cnt_r[k]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      win_r       <= win_nxt;
      cal_n_r     <= cal_n_nxt;
      v_gain_r    <= v_gain_nxt;
      i_gain_r    <= i_gain_nxt;
      v_floor_r   <= v_floor_nxt;
      i_floor_r   <= i_floor_nxt;
      last_mode_r <= last_mode_nxt;
      out_valid_r <= out_valid_nxt;
      v_ofs_r     <= v_ofs_nxt;
      i_ofs_r     <= i_ofs_nxt;
      v_sq_r      <= v_sq_nxt;
      i_sq_r      <= i_sq_nxt;
      v_cal_r     <= v_cal_nxt;
      i_cal_r     <= i_cal_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ph_r        <= ph_nxt;
    vc_r        <= vc_nxt;
    ic_r        <= ic_nxt;
    sq_v_r      <= sq_v_nxt;
    ofs_tmp_r   <= ofs_tmp_nxt;
    res_v_r     <= res_v_nxt;
    res_i_r     <= res_i_nxt;
    out_kind_r  <= out_kind_nxt;
    out_phase_r <= out_phase_nxt;
    out_v_r     <= out_v_nxt;
    out_i_r     <= out_i_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_phase = out_phase_r;
  assign out_voltage_rms  = out_v_r;
  assign out_current_rms  = out_i_r;

  // unit only started while idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_start |-> !alu_busy)
    else $error("shared unit started while busy");

  // unit completions only show up in a state that waits for one
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == rmsm_pkg::ST_CAL_DV || state_r == rmsm_pkg::ST_CAL_DI ||
                  state_r == rmsm_pkg::ST_SQ_V   || state_r == rmsm_pkg::ST_SQ_I   ||
                  state_r == rmsm_pkg::ST_DIV_V  || state_r == rmsm_pkg::ST_SQRT_V ||
                  state_r == rmsm_pkg::ST_GAIN_V || state_r == rmsm_pkg::ST_DIV_I  ||
                  state_r == rmsm_pkg::ST_SQRT_I || state_r == rmsm_pkg::ST_GAIN_I))
    else $error("unit done outside an operation state");

  // a word on a valid phase always starts processing
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ph_ok) |=> !in_ready)
    else $error("accepted word was not processed");

  // the phase counter never passes the window limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rmsm_pkg::ST_IDLE) |-> (32'(cnt_r[p]) <= MAX_WINDOW))
    else $error("sample counter past window limit");

endmodule

`default_nettype wire

// ===== hdl/rmsm_alu.sv =====
`default_nettype none

// shared radix-2 unit: shift-add multiply, restoring divide, bit-pair square root
module rmsm_alu #(
  parameter int DATA_W = 56
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  rmsm_pkg::alu_op_t           op,
  input  wire  [DATA_W-1:0]           a,
  input  wire  [DATA_W-1:0]           b,
  input  wire  [$clog2(DATA_W+1)-1:0] steps,
  output logic                        busy,
  output logic                        done,
  output logic [DATA_W-1:0]           result
);

  localparam int STEP_W = $clog2(DATA_W+1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  rmsm_pkg::alu_op_t   op_r, op_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   aux_r, aux_nxt;

  logic [DATA_W-1:0]   opa, opb;
  logic                sub;
  logic [DATA_W:0]     sum_w;
  logic                carry;

  // the one adder, add or subtract with carry out as compare
  always_comb begin
    opa = acc_r;
    opb = aux_r;
    sub = 1'b0;
    case (op_r)
      rmsm_pkg::ALU_MUL: begin
        opa = acc_r;
        opb = aux_r;
        sub = 1'b0;
      end
      rmsm_pkg::ALU_DIV: begin
        opa = {acc_r[DATA_W-2:0], quo_r[DATA_W-1]};
        opb = aux_r;
        sub = 1'b1;
      end
      rmsm_pkg::ALU_SQRT: begin
        opa = {acc_r[DATA_W-3:0], quo_r[DATA_W-1:DATA_W-2]};
        opb = {aux_r[DATA_W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        opa = acc_r;
        opb = aux_r;
        sub = 1'b0;
      end
    endcase
    sum_w = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{DATA_W{1'b0}}, sub};
    carry = sum_w[DATA_W];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    aux_nxt  = aux_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      op_nxt   = op;
      acc_nxt  = '0;
      case (op)
        rmsm_pkg::ALU_MUL: begin
          quo_nxt = b;
          aux_nxt = a;
        end
        rmsm_pkg::ALU_DIV: begin
          quo_nxt = a;
          aux_nxt = b;
        end
        default: begin
          quo_nxt = a;
          aux_nxt = '0;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      case (op_r)
        rmsm_pkg::ALU_MUL: begin
          if (quo_r[0]) begin
            acc_nxt = sum_w[DATA_W-1:0];
          end
          aux_nxt = aux_r << 1;
          quo_nxt = quo_r >> 1;
        end
        rmsm_pkg::ALU_DIV: begin
          acc_nxt = carry ? sum_w[DATA_W-1:0] : opa;
          quo_nxt = {quo_r[DATA_W-2:0], carry};
        end
        rmsm_pkg::ALU_SQRT: begin
          acc_nxt = carry ? sum_w[DATA_W-1:0] : opa;
          quo_nxt = quo_r << 2;
          aux_nxt = {aux_r[DATA_W-2:0], carry};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= rmsm_pkg::ALU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    aux_r <= aux_nxt;
  end

  always_comb begin
    case (op_r)
      rmsm_pkg::ALU_MUL:  result = acc_r;
      rmsm_pkg::ALU_DIV:  result = quo_r;
      rmsm_pkg::ALU_SQRT: result = aux_r;
      default:            result = acc_r;
    endcase
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES = rmsm_pkg::PHASE_COUNT_DEF;
  localparam int ADC_W = rmsm_pkg::ADC_BITS_DEF;
  localparam int MAXW = rmsm_pkg::MAX_WINDOW_DEF;
  localparam int PHASE_W = rmsm_pkg::PHASE_W;
  localparam int OUT_W = rmsm_pkg::OUT_W;
  localparam int OFS_W = rmsm_pkg::OFS_W;
  localparam int CNT_CFG_W = rmsm_pkg::CNT_CFG_W;
  localparam int GAIN_W = rmsm_pkg::GAIN_W;
  localparam int FLOOR_W = rmsm_pkg::FLOOR_W;
  localparam int CFG_IDX_W = rmsm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rmsm_pkg::CFG_DATA_W;
  localparam int CODE_MAX = (1 << ADC_W) - 1;
  localparam int READING_MAX = (1 << OUT_W) - 1;
  // cycles a word may still be in flight after the last result
  localparam int SETTLE = 400;
  // cycles with no handshake on any channel before giving up
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 800;

  typedef struct packed {
    logic                 cmd;
    logic [PHASE_W-1:0]   phase;
    logic [ADC_W-1:0]     vcode;
    logic [ADC_W-1:0]     icode;
  } sample_t;

  typedef struct packed {
    logic                 kind;
    logic [PHASE_W-1:0]   phase;
    logic [OUT_W-1:0]     volt;
    logic [OUT_W-1:0]     curr;
  } reading_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_command = 1'b0;
  logic [PHASE_W-1:0]    in_phase = '0;
  logic [ADC_W-1:0]      in_voltage_code = '0;
  logic [ADC_W-1:0]      in_current_code = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_result_kind;
  logic [PHASE_W-1:0]    out_result_phase;
  logic [OUT_W-1:0]      out_voltage_rms;
  logic [OUT_W-1:0]      out_current_rms;

  three_phase_rms_meter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_phase         (in_phase),
    .in_voltage_code  (in_voltage_code),
    .in_current_code  (in_current_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_result_phase (out_result_phase),
    .out_voltage_rms  (out_voltage_rms),
    .out_current_rms  (out_current_rms)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // meter model: settings and per-phase state, updated as words are accepted
  // ---------------------------------------------------------------------------
  logic [CNT_CFG_W-1:0] set_window, set_cal;
  logic [GAIN_W-1:0]    set_vgain, set_igain;
  logic [FLOOR_W-1:0]   set_vfloor, set_ifloor;

  logic               mode_now;
  logic [OFS_W-1:0]   v_ofs [PHASES];
  logic [OFS_W-1:0]   i_ofs [PHASES];
  logic [63:0]        v_sq [PHASES];
  logic [63:0]        i_sq [PHASES];
  logic [63:0]        v_cal [PHASES];
  logic [63:0]        i_cal [PHASES];
  logic [63:0]        tally [PHASES];

  sample_t  pending [$];
  reading_t readings_due [$];

  int errors = 0;
  int cyc = 0;
  bit hold_arm = 1'b0;

  function automatic void clear_sums();
    for (int p = 0; p < PHASES; p++) begin
      v_sq[p] = '0;
      i_sq[p] = '0;
      v_cal[p] = '0;
      i_cal[p] = '0;
      tally[p] = '0;
    end
  endfunction

  function automatic void meter_reset();
    set_window = rmsm_pkg::WINDOW_RST;
    set_cal = rmsm_pkg::CAL_SAMPLES_RST;
    set_vgain = rmsm_pkg::VOLT_GAIN_RST;
    set_igain = rmsm_pkg::CURR_GAIN_RST;
    set_vfloor = rmsm_pkg::VOLT_FLOOR_RST;
    set_ifloor = rmsm_pkg::CURR_FLOOR_RST;
    for (int p = 0; p < PHASES; p++) begin
      v_ofs[p] = OFS_W'(1 << (ADC_W - 1 + 4));
      i_ofs[p] = OFS_W'(1 << (ADC_W - 1 + 4));
    end
    clear_sums();
    mode_now = rmsm_pkg::MODE_MEAS;
  endfunction

  // zero acts as one, anything above the max window acts as the max
  function automatic logic [63:0] eff_count(input logic [CNT_CFG_W-1:0] c);
    if (c == 0) return 64'd1;
    if (c > MAXW) return 64'(MAXW);
    return 64'(c);
  endfunction

  // squared deviation from the offset, both in 4 fractional bits
  function automatic logic [63:0] dev_squared(input logic [ADC_W-1:0] code,
                                              input logic [OFS_W-1:0] ofs);
    logic [63:0] c, d;
    c = 64'(code) << 4;
    d = (c >= 64'(ofs)) ? c - 64'(ofs) : 64'(ofs) - c;
    return d * d;
  endfunction

  // bitwise trial root, largest r with r*r <= x
  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] r, t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] to_units(input logic [63:0] mean,
                                                input logic [GAIN_W-1:0] gain,
                                                input logic [FLOOR_W-1:0] lim);
    logic [63:0] v;
    v = (int_root(mean) * 64'(gain)) >> rmsm_pkg::GAIN_FRAC;
    if (v > 64'(READING_MAX)) v = 64'(READING_MAX);
    if (v < 64'(lim)) v = '0;
    return v[OUT_W-1:0];
  endfunction

  // advance the model by one accepted word; returns 1 when it closes a set
  function automatic bit meter_predict(input sample_t s, output reading_t r);
    int p;
    logic [63:0] n;
    r = '0;
    // out-of-range phase leaves everything alone
    if (s.phase >= PHASES) return 1'b0;
    p = int'(s.phase);
    // mode switch wipes every sum and counter
    if (s.cmd != mode_now) begin
      clear_sums();
      mode_now = s.cmd;
    end
    if (s.cmd == rmsm_pkg::MODE_CAL) begin
      n = eff_count(set_cal);
      v_cal[p] += 64'(s.vcode);
      i_cal[p] += 64'(s.icode);
      tally[p] += 64'd1;
      if (tally[p] < n) return 1'b0;
      v_ofs[p] = OFS_W'((v_cal[p] << 4) / n);
      i_ofs[p] = OFS_W'((i_cal[p] << 4) / n);
      v_cal[p] = '0;
      i_cal[p] = '0;
      tally[p] = '0;
      r.kind = rmsm_pkg::MODE_CAL;
      r.phase = s.phase;
      r.volt = v_ofs[p][OUT_W-1:0];
      r.curr = i_ofs[p][OUT_W-1:0];
      return 1'b1;
    end
    n = eff_count(set_window);
    v_sq[p] += dev_squared(s.vcode, v_ofs[p]);
    i_sq[p] += dev_squared(s.icode, i_ofs[p]);
    tally[p] += 64'd1;
    // >= so a window lowered mid-way closes on the next word
    if (tally[p] < n) return 1'b0;
    r.kind = rmsm_pkg::MODE_MEAS;
    r.phase = s.phase;
    r.volt = to_units(v_sq[p] / n, set_vgain, set_vfloor);
    r.curr = to_units(i_sq[p] / n, set_igain, set_ifloor);
    v_sq[p] = '0;
    i_sq[p] = '0;
    tally[p] = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at cycle %0d: %0s got %0d want %0d", cyc, field, got, want);
    errors++;
  endtask

  // long stretch with no idling on either side
  logic steady;
  assign steady = (cyc % 20000) >= 8000 && (cyc % 20000) < 12000;

  // ---------------------------------------------------------------------------
  // sample driver: presents words from the pending queue at the falling edge
  // ---------------------------------------------------------------------------
  sample_t cur;
  bit      in_fire = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // previous word gone (or none): offer the next one, or idle
      if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        cur = pending.pop_front();
        in_valid <= 1'b1;
        in_command <= cur.cmd;
        in_phase <= cur.phase;
        in_voltage_code <= cur.vcode;
        in_current_code <= cur.icode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted words feed the model
  always @(posedge clk) begin
    reading_t r;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      if (meter_predict(cur, r)) readings_due.push_back(r);
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_arm && !hold_done) begin
      // receiver goes quiet so the block backs up into its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(0, 99) >= 25;
    end
  end

  // result monitor: each word against the oldest expected reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected result phase", int'(out_result_phase), -1);
      end else begin
        want = readings_due.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", int'(out_result_kind), int'(want.kind));
        if (out_result_phase !== want.phase)
          report_mismatch("result_phase", int'(out_result_phase), int'(want.phase));
        if (out_voltage_rms !== want.volt)
          report_mismatch("voltage_rms", int'(out_voltage_rms), int'(want.volt));
        if (out_current_rms !== want.curr)
          report_mismatch("current_rms", int'(out_current_rms), int'(want.curr));
      end
    end
  end

  // watchdog: cycles without any handshake
  int quiet = 0;

  always @(posedge clk) begin
    cyc++;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // taken at this edge: mirror it in the model
    case (idx)
      rmsm_pkg::CFG_WINDOW:      set_window = data[CNT_CFG_W-1:0];
      rmsm_pkg::CFG_CAL_SAMPLES: set_cal = data[CNT_CFG_W-1:0];
      rmsm_pkg::CFG_VOLT_GAIN:   set_vgain = data[GAIN_W-1:0];
      rmsm_pkg::CFG_CURR_GAIN:   set_igain = data[GAIN_W-1:0];
      rmsm_pkg::CFG_VOLT_FLOOR:  set_vfloor = data[FLOOR_W-1:0];
      rmsm_pkg::CFG_CURR_FLOOR:  set_ifloor = data[FLOOR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_sample(input logic cmd, input int ph, input int v, input int i);
    sample_t s;
    s.cmd = cmd;
    s.phase = PHASE_W'(ph);
    s.vcode = ADC_W'(v);
    s.icode = ADC_W'(i);
    pending.push_back(s);
  endtask

  function automatic int near(input int center, input int spread);
    int x;
    x = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > CODE_MAX) x = CODE_MAX;
    return x;
  endfunction

  // block idle: all words taken, all readings seen, last word settled
  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] g;
    write_reg(rmsm_pkg::CFG_WINDOW, ($urandom_range(0, 7) == 0) ? '0 :
              CFG_DATA_W'($urandom_range(1, 6)));
    write_reg(rmsm_pkg::CFG_CAL_SAMPLES, CFG_DATA_W'($urandom_range(0, 5)));
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 5))
        0: g = '0;
        1: g = {GAIN_W{1'b1}};
        2: g = (k == 0) ? rmsm_pkg::VOLT_GAIN_RST : rmsm_pkg::CURR_GAIN_RST;
        3: g = CFG_DATA_W'($urandom_range(0, 2000000));
        default: g = CFG_DATA_W'($urandom());
      endcase
      write_reg((k == 0) ? rmsm_pkg::CFG_VOLT_GAIN : rmsm_pkg::CFG_CURR_GAIN, g);
    end
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 5))
        0: g = '0;
        1: g = CFG_DATA_W'(READING_MAX);
        2, 3: g = CFG_DATA_W'($urandom_range(0, 300));
        default: g = CFG_DATA_W'($urandom_range(0, READING_MAX));
      endcase
      write_reg((k == 0) ? rmsm_pkg::CFG_VOLT_FLOOR : rmsm_pkg::CFG_CURR_FLOOR, g);
    end
  endtask

  // one full calibration on every phase, codes scattered around a center
  task automatic queue_calibration(input int center, input int spread);
    int n;
    n = (set_cal == 0) ? 1 : int'(set_cal);
    for (int k = 0; k < n * PHASES; k++)
      add_sample(rmsm_pkg::MODE_CAL, k % PHASES, near(center, spread), near(center, spread));
  endtask

  // measurement words, mostly well-formed with some noise and broken windows
  task automatic queue_measure(input int count, input int center, input int amp);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        add_sample(1'($urandom_range(0, 1)), 3, $urandom_range(0, CODE_MAX),
                   $urandom_range(0, CODE_MAX));
      else if (r < 7)
        add_sample(rmsm_pkg::MODE_CAL, $urandom_range(0, PHASES - 1),
                   $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX));
      else if (r < 12)
        add_sample(rmsm_pkg::MODE_MEAS, $urandom_range(0, PHASES - 1),
                   $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX));
      else
        add_sample(rmsm_pkg::MODE_MEAS, $urandom_range(0, PHASES - 1), near(center, amp),
                   near(center, amp));
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int center;
    meter_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: long windows, so no results, just state movement
    add_sample(rmsm_pkg::MODE_MEAS, 0, 0, CODE_MAX);
    add_sample(rmsm_pkg::MODE_MEAS, 3, CODE_MAX, 0);
    add_sample(rmsm_pkg::MODE_CAL, 1, 512, 512);
    add_sample(rmsm_pkg::MODE_MEAS, 2, CODE_MAX, CODE_MAX);
    wait_idle();

    // zero counts act as one, gains at max, no floors
    write_reg(rmsm_pkg::CFG_WINDOW, '0);
    write_reg(rmsm_pkg::CFG_CAL_SAMPLES, '0);
    write_reg(rmsm_pkg::CFG_VOLT_GAIN, {GAIN_W{1'b1}});
    write_reg(rmsm_pkg::CFG_CURR_GAIN, {GAIN_W{1'b1}});
    write_reg(rmsm_pkg::CFG_VOLT_FLOOR, '0);
    write_reg(rmsm_pkg::CFG_CURR_FLOOR, '0);
    add_sample(rmsm_pkg::MODE_CAL, 0, 0, 0);
    add_sample(rmsm_pkg::MODE_CAL, 1, CODE_MAX, CODE_MAX);
    add_sample(rmsm_pkg::MODE_CAL, 2, 512, 511);
    add_sample(rmsm_pkg::MODE_CAL, 3, CODE_MAX, 0);
    // full-scale deviations saturate, zero deviation stays zero
    add_sample(rmsm_pkg::MODE_MEAS, 0, CODE_MAX, 0);
    add_sample(rmsm_pkg::MODE_MEAS, 1, 0, CODE_MAX);
    add_sample(rmsm_pkg::MODE_MEAS, 2, 512, 512);
    add_sample(rmsm_pkg::MODE_MEAS, 3, 0, 0);
    wait_idle();

    // partial windows, then the window is lowered under them
    write_reg(rmsm_pkg::CFG_WINDOW, CFG_DATA_W'(4));
    write_reg(rmsm_pkg::CFG_CAL_SAMPLES, CFG_DATA_W'(2));
    write_reg(rmsm_pkg::CFG_VOLT_GAIN, rmsm_pkg::VOLT_GAIN_RST);
    write_reg(rmsm_pkg::CFG_CURR_GAIN, rmsm_pkg::CURR_GAIN_RST);
    write_reg(rmsm_pkg::CFG_VOLT_FLOOR, CFG_DATA_W'(READING_MAX));
    write_reg(rmsm_pkg::CFG_CURR_FLOOR, '0);
    add_sample(rmsm_pkg::MODE_MEAS, 0, 700, 300);
    add_sample(rmsm_pkg::MODE_MEAS, 0, 100, 900);
    add_sample(rmsm_pkg::MODE_MEAS, 1, 600, 400);
    wait_idle();
    write_reg(rmsm_pkg::CFG_WINDOW, CFG_DATA_W'(1));
    add_sample(rmsm_pkg::MODE_MEAS, 0, 800, 200);
    add_sample(rmsm_pkg::MODE_MEAS, 1, 0, CODE_MAX);
    // mode flips back and forth on one phase
    add_sample(rmsm_pkg::MODE_CAL, 2, 300, 700);
    add_sample(rmsm_pkg::MODE_MEAS, 2, 900, 100);
    add_sample(rmsm_pkg::MODE_CAL, 2, 500, 520);
    add_sample(rmsm_pkg::MODE_CAL, 2, 510, 530);
    wait_idle();

    // random settings, each a calibration followed by measurement
    repeat (8) begin
      random_settings();
      center = $urandom_range(380, 640);
      queue_calibration(center, $urandom_range(0, 40));
      case ($urandom_range(0, 3))
        0: queue_measure(45, center, 2);
        1: queue_measure(45, center, 50);
        2: queue_measure(45, center, 300);
        default: queue_measure(45, center, 511);
      endcase
      wait_idle();
    end

    // each valid-phase measurement word closes a window while the receiver holds off
    write_reg(rmsm_pkg::CFG_WINDOW, CFG_DATA_W'(1));
    hold_arm = 1'b1;
    queue_measure(40, 512, 400);
    wait_idle();

    // counts above the max window clamp to it, so these sets stay open
    write_reg(rmsm_pkg::CFG_CAL_SAMPLES, CFG_DATA_W'({CNT_CFG_W{1'b1}}));
    write_reg(rmsm_pkg::CFG_WINDOW, CFG_DATA_W'({CNT_CFG_W{1'b1}}));
    for (int k = 0; k < 30; k++)
      add_sample(rmsm_pkg::MODE_CAL, 0, $urandom_range(0, CODE_MAX),
                 $urandom_range(0, CODE_MAX));
    for (int k = 0; k < 30; k++)
      add_sample(rmsm_pkg::MODE_MEAS, $urandom_range(0, PHASES - 1),
                 $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX));
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
